// ===== rtl/sbs_pkg.sv =====
// Shared constants and controller/datapath interface types for the SOS1 branch split block.
package sbs_pkg;

  localparam int MAX_SET_VARS_DEF = 64;

  localparam int VAL_W     = 48;
  localparam int TOL_W     = 24;
  localparam int SUM_OUT_W = 54;
  localparam int CNT_OUT_W = 7;
  localparam int SCORE_W   = 18;

  localparam logic [TOL_W-1:0] TOL_RESET = 24'd17;

  typedef struct packed {
    logic accept;
    logic walk_start;
    logic walk_en;
    logic score;
    logic emit;
  } sbs_cmd_t;

  typedef struct packed {
    logic cand;
    logic walk_done;
  } sbs_stat_t;

endpackage

// ===== rtl/sos1_branch_split.sv =====
// Top level of the SOS1 branch split block: controller and datapath.
//
// Usage: the variables of one SOS1 set are sent one request per cycle,
// while busy is low, on in_value, in_lower_bound, in_upper_bound and
// in_last_var. A request is taken at a rising edge where start is high
// and busy is low. Each variable is stored with its free flag, and the
// running nonzero count and sum are updated as it loads. Variables past
// MAX_SET_VARS are dropped and flagged. The request with in_last_var set
// closes the set; busy then rises, and for a set that is a branching
// candidate a sequencer walks the stored set once through the store's
// single read port, one entry per cycle. The result appears for exactly
// one cycle with out_valid high, and the receiver cannot stall it. busy
// falls as out_valid rises. zero_tol is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while the block is idle, which
// the block itself does not enforce.
// Reset (rst_n low, synchronous) empties the set, clears the flags and
// loads the tolerance with its default; the store needs no clearing.
module sos1_branch_split import sbs_pkg::*; #(
  parameter int MAX_SET_VARS = MAX_SET_VARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [VAL_W-1:0]     in_value,
  input  logic signed [VAL_W-1:0]     in_lower_bound,
  input  logic signed [VAL_W-1:0]     in_upper_bound,
  input  logic                        in_last_var,
  input  logic                        cfg_wr_en,
  input  logic [TOL_W-1:0]            cfg_wr_data,
  output logic                        out_valid,
  output logic                        out_feasible,
  output logic                        out_is_candidate,
  output logic [CNT_OUT_W-1:0]        out_nonzero_count,
  output logic signed [SUM_OUT_W-1:0] out_nonzero_sum,
  output logic [CNT_OUT_W-1:0]        out_left_end,
  output logic [CNT_OUT_W-1:0]        out_right_start,
  output logic [CNT_OUT_W-1:0]        out_left_count,
  output logic [CNT_OUT_W-1:0]        out_right_count,
  output logic signed [SUM_OUT_W-1:0] out_left_sum,
  output logic signed [SUM_OUT_W-1:0] out_right_sum,
  output logic signed [SCORE_W-1:0]   out_branch_score,
  output logic                        out_set_overflow
);

  sbs_cmd_t             cmd;
  sbs_stat_t            stat;
  logic [CNT_OUT_W-1:0] left_end;

  sbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_var (in_last_var),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  sbs_datapath #(
    .MAX_SET_VARS (MAX_SET_VARS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_value          (in_value),
    .in_lower_bound    (in_lower_bound),
    .in_upper_bound    (in_upper_bound),
    .out_valid         (out_valid),
    .out_feasible      (out_feasible),
    .out_is_candidate  (out_is_candidate),
    .out_nonzero_count (out_nonzero_count),
    .out_nonzero_sum   (out_nonzero_sum),
    .out_left_end      (left_end),
    .out_left_count    (out_left_count),
    .out_right_count   (out_right_count),
    .out_left_sum      (out_left_sum),
    .out_right_sum     (out_right_sum),
    .out_branch_score  (out_branch_score),
    .out_set_overflow  (out_set_overflow)
  );

  // The right side always begins where the left walk ended.
  assign out_left_end    = left_end;
  assign out_right_start = left_end;

endmodule

// ===== rtl/sbs_ctrl.sv =====
// Controller state machine that sequences loading, the split walk and the result.
module sbs_ctrl import sbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_last_var,
  input  sbs_stat_t stat,
  output sbs_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_WALK,
    S_SCORE,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (start && !busy_r && in_last_var) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.cand ? S_WALK : S_OUT;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_SCORE;
        end
      end
      S_SCORE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    busy_nxt = (state_nxt != S_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    cmd.accept     = start && !busy_r;
    cmd.walk_start = (state_r == S_CHECK);
    cmd.walk_en    = (state_r == S_WALK);
    cmd.score      = (state_r == S_SCORE);
    cmd.emit       = (state_r == S_OUT);
  end

  assign busy = busy_r;

endmodule

// ===== rtl/sbs_datapath.sv =====
// Datapath: set store, running nonzero totals, split walk, score and result registers.
module sbs_datapath import sbs_pkg::*; #(
  parameter int MAX_SET_VARS = MAX_SET_VARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sbs_cmd_t                    cmd,
  output sbs_stat_t                   stat,
  input  logic                        cfg_wr_en,
  input  logic [TOL_W-1:0]            cfg_wr_data,
  input  logic signed [VAL_W-1:0]     in_value,
  input  logic signed [VAL_W-1:0]     in_lower_bound,
  input  logic signed [VAL_W-1:0]     in_upper_bound,
  output logic                        out_valid,
  output logic                        out_feasible,
  output logic                        out_is_candidate,
  output logic [CNT_OUT_W-1:0]        out_nonzero_count,
  output logic signed [SUM_OUT_W-1:0] out_nonzero_sum,
  output logic [CNT_OUT_W-1:0]        out_left_end,
  output logic [CNT_OUT_W-1:0]        out_left_count,
  output logic [CNT_OUT_W-1:0]        out_right_count,
  output logic signed [SUM_OUT_W-1:0] out_left_sum,
  output logic signed [SUM_OUT_W-1:0] out_right_sum,
  output logic signed [SCORE_W-1:0]   out_branch_score,
  output logic                        out_set_overflow
);

  localparam int CNT_W  = $clog2(MAX_SET_VARS + 1);
  localparam int ADDR_W = $clog2(MAX_SET_VARS);
  localparam int ACC_W  = VAL_W + CNT_W;
  localparam int CMP_W  = ACC_W + 2;
  localparam int PROD_W = 2 * (CNT_W + 1);
  localparam int SCF_W  = PROD_W + 5;
  localparam int CX_W   = CNT_W + CNT_OUT_W;
  localparam int SX_W   = ACC_W + SUM_OUT_W;
  localparam int SCX_W  = SCF_W + SCORE_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SET_VARS);

  // Each entry holds the free flag above the stored value.
  logic [VAL_W:0] mem [0:MAX_SET_VARS-1];
  logic [VAL_W:0] mem_q_r;

  logic [TOL_W-1:0]        tol_r;
  logic [CNT_W-1:0]        fill_r;
  logic [CNT_W-1:0]        nz_cnt_r;
  logic signed [ACC_W-1:0] nz_sum_r;
  logic                    ovf_r;

  logic [CNT_W-1:0]        rd_idx_r;
  logic [ADDR_W-1:0]       rd_pos_r;
  logic                    rd_vld_r;
  logic                    stopped_r;
  logic [CNT_W-1:0]        lcnt_r;
  logic [CNT_W-1:0]        rcnt_r;
  logic [CNT_W-1:0]        lend_r;
  logic signed [ACC_W-1:0] psum_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                    out_valid_r;

  // Load-side tests.
  logic signed [VAL_W:0]   val_x;
  logic signed [VAL_W:0]   tol_x;
  logic signed [VAL_W:0]   diff_x;
  logic                    nz_hit;
  logic                    is_free;
  logic                    has_room;

  assign val_x    = {in_value[VAL_W-1], in_value};
  assign tol_x    = $signed((VAL_W+1)'(tol_r));
  assign diff_x   = {in_upper_bound[VAL_W-1], in_upper_bound}
                  - {in_lower_bound[VAL_W-1], in_lower_bound};
  assign nz_hit   = val_x > tol_x;
  assign is_free  = diff_x > tol_x;
  assign has_room = (fill_r != MAX_CNT);

  // Walk-side split tests, worked in doubled form so no halves appear.
  logic signed [VAL_W-1:0] q_val;
  logic                    q_free;
  logic signed [CMP_W-1:0] v_c;
  logic signed [CMP_W-1:0] p_c;
  logic signed [CMP_W-1:0] n_c;
  logic signed [CMP_W-1:0] sum1;
  logic signed [CMP_W-1:0] sum2;
  logic                    cond1;
  logic                    cond2;
  logic                    issue;
  logic                    cand;

  assign q_val  = $signed(mem_q_r[VAL_W-1:0]);
  assign q_free = mem_q_r[VAL_W];
  assign v_c    = CMP_W'(q_val);
  assign p_c    = CMP_W'(psum_r);
  assign n_c    = CMP_W'(nz_sum_r);
  assign sum1   = (p_c + v_c) <<< 1;
  assign sum2   = v_c + (p_c <<< 1);
  assign cond1  = sum1 < n_c;
  assign cond2  = sum2 < n_c;
  assign issue  = cmd.walk_en && (rd_idx_r != fill_r);
  assign cand   = (nz_cnt_r > CNT_W'(1));

  assign stat.cand      = cand;
  assign stat.walk_done = (rd_idx_r == fill_r) && !rd_vld_r;

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.accept && has_room) begin
      mem[fill_r[ADDR_W-1:0]] <= {is_free, in_value};
    end
    if (issue) begin
      mem_q_r <= mem[rd_idx_r[ADDR_W-1:0]];
    end
  end

  // Tolerance register and running set totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      fill_r   <= '0;
      nz_cnt_r <= '0;
      nz_sum_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (cmd.emit) begin
        fill_r   <= '0;
        nz_cnt_r <= '0;
        nz_sum_r <= '0;
        ovf_r    <= 1'b0;
      end else if (cmd.accept) begin
        if (has_room) begin
          fill_r <= fill_r + CNT_W'(1);
          if (nz_hit) begin
            nz_cnt_r <= nz_cnt_r + CNT_W'(1);
            nz_sum_r <= nz_sum_r + ACC_W'(in_value);
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Split walk: one stored entry per cycle, left side until the split point,
  // then free entries are counted for the right side.
  logic signed [CNT_W:0] lm1;
  logic signed [CNT_W:0] rm1;

  assign lm1 = $signed({1'b0, lcnt_r}) - $signed((CNT_W+1)'(1));
  assign rm1 = $signed({1'b0, rcnt_r}) - $signed((CNT_W+1)'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      stopped_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.walk_start) begin
      rd_vld_r  <= 1'b0;
      stopped_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (rd_vld_r && q_free && !stopped_r && !cond1) begin
        stopped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      lcnt_r <= '0;
      rcnt_r <= '0;
      lend_r <= '0;
      psum_r <= '0;
      prod_r <= '0;
    end else begin
      if (issue) begin
        rd_pos_r <= rd_idx_r[ADDR_W-1:0];
      end
      if (rd_vld_r && q_free) begin
        if (stopped_r) begin
          rcnt_r <= rcnt_r + CNT_W'(1);
        end else begin
          if (cond1 || cond2) begin
            lcnt_r <= lcnt_r + CNT_W'(1);
            psum_r <= psum_r + ACC_W'(q_val);
          end
          if (!cond1) begin
            lend_r <= CNT_W'(rd_pos_r) + CNT_W'(1);
          end
        end
      end
      if (cmd.score) begin
        if (!stopped_r) begin
          lend_r <= fill_r;
        end
        prod_r <= PROD_W'(lm1) * PROD_W'(rm1);
      end
    end
  end

  // Result formation; counts and sums wrap to their field widths.
  logic [CX_W-1:0]          nz_cnt_x;
  logic [CX_W-1:0]          lend_x;
  logic [CX_W-1:0]          lcnt_x;
  logic [CX_W-1:0]          rcnt_x;
  logic signed [SX_W-1:0]   nz_sum_x;
  logic signed [SX_W-1:0]   psum_x;
  logic signed [SX_W-1:0]   rsum_x;
  logic signed [SCF_W-1:0]  score_b;
  logic signed [SCF_W-1:0]  score20;
  logic signed [SCX_W-1:0]  score_x;

  assign nz_cnt_x = CX_W'(nz_cnt_r);
  assign lend_x   = CX_W'(lend_r);
  assign lcnt_x   = CX_W'(lcnt_r);
  assign rcnt_x   = CX_W'(rcnt_r);
  assign nz_sum_x = SX_W'(nz_sum_r);
  assign psum_x   = SX_W'(psum_r);
  assign rsum_x   = nz_sum_x - psum_x;
  assign score_b  = SCF_W'(prod_r);
  // Times twenty as sixteen plus four.
  assign score20  = (score_b <<< 4) + (score_b <<< 2);
  assign score_x  = SCX_W'(score20);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_feasible      <= !cand;
      out_is_candidate  <= cand;
      out_nonzero_count <= nz_cnt_x[CNT_OUT_W-1:0];
      out_nonzero_sum   <= nz_sum_x[SUM_OUT_W-1:0];
      out_left_end      <= lend_x[CNT_OUT_W-1:0];
      out_left_count    <= lcnt_x[CNT_OUT_W-1:0];
      out_right_count   <= rcnt_x[CNT_OUT_W-1:0];
      out_left_sum      <= psum_x[SUM_OUT_W-1:0];
      out_right_sum     <= cand ? rsum_x[SUM_OUT_W-1:0] : '0;
      out_branch_score  <= score_x[SCORE_W-1:0];
      out_set_overflow  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
